// ===== hw/rtl/weighted_random_select_defines.svh =====
// ----------------------------------------------------------------------------
// Weighted random select assertion macros
// Shared property shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECT_DEFINES_SVH
`define WEIGHTED_RANDOM_SELECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WRS_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
// next-cycle implication
`define WRS_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define WRS_ASSERT_IMP(label, cond, prop)
`define WRS_ASSERT_NXT(label, cond, prop)
`endif

`endif

// ===== hw/rtl/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted random select package
// Field widths and fixed constants of the selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

	localparam int WEIGHT_W  = 16;  // one slot weight
	localparam int RAND_W    = 31;  // random value field
	localparam int SLOT_W    = 3;   // slot index field
	localparam int SUM_W     = 19;  // eight weights summed
	localparam int NUM_REGS  = 8;   // weight registers
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = 5;   // byte address of the weight registers
	localparam int PFX_LVLS  = 3;   // levels of the prefix-sum tree
	localparam int DATA_W    = 32;  // APB data
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 8;

	localparam logic [1:0] CFG_HOLD = 2'(PFX_LVLS - 1);

endpackage

`default_nettype wire

// ===== hw/rtl/weighted_random_select.sv =====
// ----------------------------------------------------------------------------
// Weighted random select
// Picks a slot with probability proportional to its programmed weight.
// ----------------------------------------------------------------------------
// Usage:
//   Program the slot weights over the APB port (weight i at byte address 4*i,
//   a weight of zero leaves the slot out). Each transfer on the s_ channel
//   carries one random value; each transfer on the m_ channel returns one
//   selection: m_tuser says whether a slot was chosen (zero when all weights
//   are zero) and m_tdata holds the slot index.
//   The pipeline holds one input stage, 31 remainder stages (one quotient
//   bit of the 31-bit random value per stage, a 20-bit compare and subtract
//   each) and one scan stage that compares the remainder against all prefix
//   sums. It takes one request per cycle while s_tready is high.
//   The prefix sums of the weights run through a three-level registered tree,
//   so s_tready stays low in the access cycle of a register write and while
//   the hold counter hold_q counts down after it.
//   Reset clears all weights and empties the pipeline. When the receiver
//   stalls, results stay in the pipeline; bubbles close up and s_tready drops
//   only once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_random_select_defines.svh"

module weighted_random_select #(
	parameter int SLOTS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// APB configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [wrs_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [wrs_pkg::DATA_W-1:0]      pwdata,
	output logic      [wrs_pkg::DATA_W-1:0]      prdata,
	output logic                                 pready,
	// request stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [wrs_pkg::IN_TDATA_W-1:0]  s_tdata,   // [30:0] random_value
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [wrs_pkg::OUT_TDATA_W-1:0] m_tdata,   // [2:0] selected_slot
	output logic                                 m_tuser    // [0] selected_valid
);

	localparam int SUM_W  = wrs_pkg::SUM_W;
	localparam int RAND_W = wrs_pkg::RAND_W;
	localparam int NSTG   = RAND_W + 2;  // input, remainder steps, scan
	localparam int LAST   = NSTG - 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [wrs_pkg::WEIGHT_W-1:0]  weight_q [wrs_pkg::NUM_REGS];
	logic [1:0]                    hold_q;
	logic                          cfg_wr;
	logic [wrs_pkg::REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[wrs_pkg::ADDR_W-1:2];
	assign prdata  = wrs_pkg::DATA_W'(weight_q[cfg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrs_pkg::NUM_REGS; i++) begin
				weight_q[i] <= '0;
			end
			hold_q <= '0;
		end else begin
			if (cfg_wr) begin
				weight_q[cfg_idx] <= pwdata[wrs_pkg::WEIGHT_W-1:0];
				hold_q            <= wrs_pkg::CFG_HOLD;
			end else if (hold_q != '0) begin
				hold_q <= hold_q - 2'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Prefix sums of the weights, log-step tree with a register per level
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] pfx_q [wrs_pkg::PFX_LVLS][SLOTS];
	logic [SUM_W-1:0] total;

	for (genvar d = 0; d < wrs_pkg::PFX_LVLS; d++) begin : g_lvl
		for (genvar i = 0; i < SLOTS; i++) begin : g_slot
			logic [SUM_W-1:0] own;
			logic [SUM_W-1:0] far;

			if (d == 0) begin : g_base
				assign own = SUM_W'(weight_q[i]);
				if (i >= 1) begin : g_add
					assign far = SUM_W'(weight_q[i-1]);
				end else begin : g_none
					assign far = '0;
				end
			end else begin : g_upper
				assign own = pfx_q[d-1][i];
				if (i >= (1 << d)) begin : g_add
					assign far = pfx_q[d-1][i-(1 << d)];
				end else begin : g_none
					assign far = '0;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pfx_q[d][i] <= '0;
				end else begin
					pfx_q[d][i] <= own + far;
				end
			end
		end
	end

	assign total = pfx_q[wrs_pkg::PFX_LVLS-1][SLOTS-1];

	// ------------------------------------------------------------------
	// Pipeline control: each stage advances when empty or when the next one does
	// ------------------------------------------------------------------
	logic             v_s   [NSTG];
	logic             en    [NSTG];
	logic [RAND_W-1:0] rnd_s [LAST];
	logic [SUM_W-1:0]  rem_s [LAST];
	logic                     sel_valid_s;
	logic [wrs_pkg::SLOT_W-1:0] sel_slot_s;

	always_comb begin
		en[LAST] = !v_s[LAST] || m_tready;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign s_tready = en[0] && (hold_q == '0) && !cfg_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				v_s[0] <= s_tvalid && s_tready;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	// input stage
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rnd_s[0] <= s_tdata[RAND_W-1:0];
			rem_s[0] <= '0;
		end
	end

	// remainder stages: shift in one random bit, subtract the total if it fits
	for (genvar k = 1; k < LAST; k++) begin : g_div
		logic [SUM_W:0] trial;
		logic [SUM_W:0] diff;

		assign trial = {rem_s[k-1], rnd_s[k-1][RAND_W-k]};
		assign diff  = trial - {1'b0, total};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rnd_s[k] <= rnd_s[k-1];
				rem_s[k] <= (trial >= {1'b0, total}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			end
		end
	end

	// scan stage: first slot whose prefix sum exceeds the remainder
	logic [wrs_pkg::SLOT_W-1:0] scan_slot;

	always_comb begin
		scan_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rem_s[LAST-1] < pfx_q[wrs_pkg::PFX_LVLS-1][i]) begin
				scan_slot = wrs_pkg::SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			sel_valid_s <= (total != '0);
			sel_slot_s  <= (total != '0) ? scan_slot : '0;
		end
	end

	assign m_tvalid = v_s[LAST];
	assign m_tuser  = sel_valid_s;
	assign m_tdata  = wrs_pkg::OUT_TDATA_W'(sel_slot_s);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`WRS_ASSERT_NXT(a_hold_after_cfg, cfg_wr, !s_tready)
	`WRS_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v_s[0])
	`WRS_ASSERT_IMP(a_none_is_zero, m_tvalid && !m_tuser, sel_slot_s == '0)
	`WRS_ASSERT_IMP(a_slot_in_range, m_tvalid && m_tuser, 32'(sel_slot_s) < SLOTS)

endmodule

`default_nettype wire

// ===== tb/sv/weighted_random_select_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted random select testbench
// Programs the slot weights over APB, streams random values into the
// selector with bursty input and a stalling output side, and checks every
// returned selection against an in-line prediction of the weighted pick.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_random_select_tb;

	localparam int WEIGHT_W    = wrs_pkg::WEIGHT_W;
	localparam int RAND_W      = wrs_pkg::RAND_W;
	localparam int SLOT_W      = wrs_pkg::SLOT_W;
	localparam int NUM_REGS    = wrs_pkg::NUM_REGS;
	localparam int ADDR_W      = wrs_pkg::ADDR_W;
	localparam int DATA_W      = wrs_pkg::DATA_W;
	localparam int IN_TDATA_W  = wrs_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = wrs_pkg::OUT_TDATA_W;

	localparam int NUM_SLOTS  = 8;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_MAX  = 20000;
	localparam int TAIL_WAIT  = 40;
	localparam int MAX_PRINTS = 100;
	localparam logic [RAND_W-1:0] RAND_MAX = '1;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} selection_t;

	typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;
	typedef enum int {W_MIXED, W_TINY, W_SINGLE, W_NONE, W_FULL} weight_kind_t;

	class selection_scoreboard;
		logic [WEIGHT_W-1:0] slot_weight [NUM_REGS];
		selection_t          expected_picks [$];
		int                  slot_hits [NUM_REGS];
		int                  errors;
		int                  requests;
		int                  checked;
		int                  none_count;
		int                  reg_writes;

		function new();
			foreach (slot_weight[i]) begin
				slot_weight[i] = '0;
				slot_hits[i]   = 0;
			end
			errors     = 0;
			requests   = 0;
			checked    = 0;
			none_count = 0;
			reg_writes = 0;
		endfunction

		function void set_weight(int idx, logic [WEIGHT_W-1:0] value);
			slot_weight[idx] = value;
			reg_writes++;
		endfunction

		function int unsigned prefix_at(int last);
			int unsigned sum;
			sum = 0;
			for (int i = 0; i < NUM_SLOTS && i <= last; i++)
				sum += slot_weight[i];
			return sum;
		endfunction

		function int unsigned total_weight();
			return prefix_at(NUM_SLOTS - 1);
		endfunction

		// first slot whose running sum exceeds the reduced value
		function selection_t pick_slot(logic [RAND_W-1:0] rnd);
			selection_t  pick;
			int unsigned total;
			int unsigned reduced;
			int unsigned running;
			pick    = '0;
			running = 0;
			total   = total_weight();
			if (total == 0)
				return pick;
			reduced = rnd % total;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				running += slot_weight[i];
				if (reduced < running) begin
					pick.valid = 1'b1;
					pick.slot  = SLOT_W'(i);
					return pick;
				end
			end
			return pick;
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("[%0t] error: %s", $time, msg);
		endtask

		function void note_request(logic [RAND_W-1:0] rnd);
			requests++;
			expected_picks = {expected_picks, pick_slot(rnd)};
		endfunction

		task check_selection(logic valid, logic [SLOT_W-1:0] slot);
			selection_t want;
			if (expected_picks.size() == 0) begin
				report_mismatch($sformatf("selection with nothing pending (valid %0d slot %0d)",
					valid, slot));
			end else begin
				want = expected_picks.pop_front();
				checked++;
				if (valid !== want.valid)
					report_mismatch($sformatf("selection %0d: valid %0d, expected %0d",
						checked, valid, want.valid));
				if (slot !== want.slot)
					report_mismatch($sformatf("selection %0d: slot %0d, expected %0d",
						checked, slot, want.slot));
				if (!want.valid)
					none_count++;
				else
					slot_hits[want.slot]++;
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [30:0] random_value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [2:0] selected_slot
	logic                   m_tuser;   // [0] selected_valid

	selection_scoreboard sb = new();
	rx_mode_t            rx_mode = RX_ALWAYS;
	bit                  hold_request = 1'b0;

	weighted_random_select #(
		.SLOTS(NUM_SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Run timed out with %0d selections pending", sb.pending());
		$display("Mismatches found");
		$finish;
	end

	// watch both channels; results are checked before the new request is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_selection(m_tuser, m_tdata[SLOT_W-1:0]);
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata[RAND_W-1:0]);
		end
	end

	// result side: stall pattern per phase, plus one long hold-off on request
	initial begin
		int hold_left;
		int beat;
		hold_left = 0;
		beat      = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			beat++;
			if (hold_request) begin
				hold_left    = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  m_tready <= 1'b1;
					RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: m_tready <= ((beat % 7) < 4);
					default:    m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic apb_write(input int idx, input logic [WEIGHT_W-1:0] value);
		// upper data bits are noise; only the low 16 bits land in the register
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_weight(idx, value);
		// leave the bus idle between transfers
		@(posedge clk);
	endtask

	task automatic program_weights(input weight_kind_t kind);
		int                  lone;
		logic [WEIGHT_W-1:0] value;
		lone = $urandom_range(0, NUM_REGS - 1);
		for (int i = 0; i < NUM_REGS; i++) begin
			case (kind)
				W_MIXED: begin
					case ($urandom_range(0, 3))
						0:       value = '0;
						1:       value = '1;
						default: value = WEIGHT_W'($urandom);
					endcase
				end
				W_TINY:   value = WEIGHT_W'($urandom_range(0, 4));
				W_SINGLE: value = (i == lone) ? WEIGHT_W'($urandom_range(1, 65535)) : '0;
				W_NONE:   value = '0;
				default:  value = '1;
			endcase
			apb_write(i, value);
		end
	endtask

	task automatic offer(input logic [RAND_W-1:0] rnd);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rnd};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_input(input int cycles);
		s_tvalid <= 1'b0;
		s_tdata  <= {1'b0, RAND_W'($urandom)};
		repeat (cycles) @(posedge clk);
	endtask

	// stop offering and wait for every pending selection to come back
	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d selections never returned", sb.pending()));
	endtask

	// mix of full-range values, values near the total and values on slot edges
	function automatic logic [RAND_W-1:0] draw_value();
		longint      v;
		int unsigned total;
		total = sb.total_weight();
		if (total == 0 || $urandom_range(0, 1) == 0)
			return RAND_W'($urandom);
		if ($urandom_range(0, 1) == 0)
			return RAND_W'($urandom_range(0, 2 * total + 2));
		v = longint'($urandom_range(0, int'(RAND_MAX) / total)) * total
			+ sb.prefix_at($urandom_range(0, NUM_SLOTS - 1)) + $urandom_range(0, 2) - 1;
		if (v < 0)
			v = 0;
		if (v > longint'(RAND_MAX))
			v = RAND_MAX;
		return RAND_W'(v);
	endfunction

	task automatic run_items(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst) offer(draw_value());
			left -= burst;
			if ($urandom_range(0, 9) >= 3)
				idle_input($urandom_range(1, 6));
		end
	endtask

	initial begin
		weight_kind_t plan [8];
		int unsigned  edge_sum;
		plan = '{W_MIXED, W_TINY, W_SINGLE, W_MIXED, W_NONE, W_FULL, W_TINY, W_MIXED};

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset weights are all zero: nothing can be chosen
		offer('0);
		offer(RAND_MAX);
		offer(RAND_W'($urandom));
		drain();

		// every slot at full weight, values on both sides of each slot edge
		program_weights(W_FULL);
		offer('0);
		offer(RAND_MAX);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			edge_sum = sb.prefix_at(i);
			offer(RAND_W'(edge_sum - 1));
			offer(RAND_W'(edge_sum));
		end
		drain();

		// only the last slot has weight, and the smallest one
		for (int i = 0; i < NUM_REGS; i++)
			apb_write(i, (i == NUM_REGS - 1) ? WEIGHT_W'(1) : '0);
		offer('0);
		offer(RAND_MAX);
		offer(RAND_W'($urandom));
		drain();

		foreach (plan[p]) begin
			program_weights(plan[p]);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (p == 1) begin
				// hold the result side off while requests keep coming
				hold_request = 1'b1;
				repeat (150) offer(draw_value());
				rx_mode = RX_MOSTLY;
			end
			if (p == 2) begin
				run_items(100);
				drain();
				run_items(100);
			end else begin
				run_items(200);
			end
			drain();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d selections left over", sb.pending()));

		$display("Sent %0d requests, checked %0d selections across %0d register writes",
			sb.requests, sb.checked, sb.reg_writes);
		$display("No-selection results %0d; picks per slot %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.none_count, sb.slot_hits[0], sb.slot_hits[1], sb.slot_hits[2], sb.slot_hits[3],
			sb.slot_hits[4], sb.slot_hits[5], sb.slot_hits[6], sb.slot_hits[7]);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
